>>> rtl/ose_pkg.sv
// ----------------------------------------------------------------------------
// ose_pkg
// Shared widths, operation and error codes, and the result record of the
// operand stack engine.
// ----------------------------------------------------------------------------
package ose_pkg;

    localparam int unsigned FUNC_W          = 3;
    localparam int unsigned WORD_W          = 64;
    localparam int unsigned CNT_W           = 11;
    localparam int unsigned DEPTH_W         = 11;
    localparam int unsigned ERR_W           = 2;
    localparam int unsigned STACK_DEPTH_DEF = 1024;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH        = 3'd0,
        OP_POP         = 3'd1,
        OP_RESERVE     = 3'd2,
        OP_DROP        = 3'd3,
        OP_REVERSE     = 3'd4,
        OP_PEEK_TOP    = 3'd5,
        OP_PEEK_BOTTOM = 3'd6
    } func_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } err_t;

    typedef struct packed {
        logic [WORD_W-1:0]  data;
        logic [DEPTH_W-1:0] depth;
        logic [ERR_W-1:0]   error;
    } rsp_t;

endpackage

>>> rtl/ose_ifs.sv
// ----------------------------------------------------------------------------
// ose_ifs
// Valid/ready channels of the operand stack engine: command in, response out.
// ----------------------------------------------------------------------------
interface ose_cmd_if import ose_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  count;

    modport source (output valid, output func, output value, output count, input ready);
    modport sink   (input valid, input func, input value, input count, output ready);
endinterface

interface ose_rsp_if import ose_pkg::*;;
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  data;
    logic [DEPTH_W-1:0] depth;
    logic [ERR_W-1:0]   error;

    modport source (output valid, output data, output depth, output error, input ready);
    modport sink   (input valid, input data, input depth, input error, output ready);
endinterface

>>> rtl/ose_mem.sv
// ----------------------------------------------------------------------------
// ose_mem
// Stack storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ose_mem import ose_pkg::*; #(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WORD_W-1:0] rdata_a,
    output logic [WORD_W-1:0] rdata_b
);

    logic [WORD_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> rtl/ose_ctrl.sv
// ----------------------------------------------------------------------------
// ose_ctrl
// Sequencer: bound checks, fill level, memory access and the swap loop that
// walks two pointers through the memory for reverse.
// ----------------------------------------------------------------------------
module ose_ctrl import ose_pkg::*; #(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    ose_cmd_if.sink           cmd,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [WORD_W-1:0] mem_wdata,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_raddr_a,
    output logic [ADDR_W-1:0] mem_raddr_b,
    input  logic [WORD_W-1:0] mem_rdata_a,
    input  logic [WORD_W-1:0] mem_rdata_b,
    output logic              res_valid,
    input  logic              res_ready,
    output rsp_t              res
);

    localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned CW    = ((LVL_W > CNT_W) ? LVL_W : CNT_W) + 1;
    localparam logic [CW-1:0] DEPTH_E = CW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [LVL_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    err_t              err_reg, err_next;
    logic              rd_reg, rd_next;

    logic [CW-1:0]     fill_e;
    logic [CW-1:0]     cnt_e;
    logic [ADDR_W-1:0] top_idx;
    logic [ADDR_W-1:0] lo_step;
    logic [ADDR_W-1:0] hi_step;
    logic [ADDR_W:0]   gap;
    logic              more;

    assign fill_e  = CW'(fill_reg);
    assign cnt_e   = CW'(cmd.count);
    assign top_idx = ADDR_W'(fill_e - CW'(1));

    // pointer step unit shared by every swap
    assign lo_step = lo_reg + ADDR_W'(1);
    assign hi_step = hi_reg - ADDR_W'(1);
    assign gap     = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign more    = gap > (ADDR_W + 1)'(2);

    assign cmd.ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res.data  = rd_reg ? mem_rdata_a : '0;
    assign res.depth = fill_e[DEPTH_W-1:0];
    assign res.error = err_reg;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        err_next    = err_reg;
        rd_next     = rd_reg;
        mem_we      = 1'b0;
        mem_waddr   = lo_reg;
        mem_wdata   = mem_rdata_b;
        mem_re      = 1'b0;
        mem_raddr_a = lo_reg;
        mem_raddr_b = hi_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    err_next   = ERR_NONE;
                    rd_next    = 1'b0;
                    state_next = ST_RESP;
                    case (func_t'(cmd.func))
                        OP_PUSH:
                        begin
                            if (fill_e >= DEPTH_E)
                            begin
                                err_next = ERR_OVERFLOW;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = fill_e[ADDR_W-1:0];
                                mem_wdata = cmd.value;
                                fill_next = LVL_W'(fill_e + CW'(1));
                            end
                        end
                        OP_POP:
                        begin
                            if (fill_e == '0)
                            begin
                                err_next = ERR_UNDERFLOW;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                mem_raddr_a = top_idx;
                                rd_next     = 1'b1;
                                fill_next   = LVL_W'(fill_e - CW'(1));
                            end
                        end
                        OP_RESERVE:
                        begin
                            if ((fill_e + cnt_e) > DEPTH_E)
                            begin
                                err_next = ERR_OVERFLOW;
                            end
                            else
                            begin
                                fill_next = LVL_W'(fill_e + cnt_e);
                            end
                        end
                        OP_DROP:
                        begin
                            if (cnt_e > fill_e)
                            begin
                                err_next = ERR_UNDERFLOW;
                            end
                            else
                            begin
                                fill_next = LVL_W'(fill_e - cnt_e);
                            end
                        end
                        OP_REVERSE:
                        begin
                            if (cnt_e > fill_e)
                            begin
                                err_next = ERR_UNDERFLOW;
                            end
                            else if (cnt_e > CW'(1))
                            begin
                                lo_next     = ADDR_W'(fill_e - cnt_e);
                                hi_next     = top_idx;
                                mem_re      = 1'b1;
                                mem_raddr_a = ADDR_W'(fill_e - cnt_e);
                                mem_raddr_b = top_idx;
                                state_next  = ST_SWAP_A;
                            end
                        end
                        OP_PEEK_TOP:
                        begin
                            if (cnt_e >= fill_e)
                            begin
                                err_next = ERR_UNDERFLOW;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                mem_raddr_a = ADDR_W'(fill_e - CW'(1) - cnt_e);
                                rd_next     = 1'b1;
                            end
                        end
                        OP_PEEK_BOTTOM:
                        begin
                            if (cnt_e >= fill_e)
                            begin
                                err_next = ERR_UNDERFLOW;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                mem_raddr_a = cnt_e[ADDR_W-1:0];
                                rd_next     = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWAP_A:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg;
                mem_wdata  = mem_rdata_b;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg;
                mem_wdata = mem_rdata_a;
                lo_next   = lo_step;
                hi_next   = hi_step;
                if (more)
                begin
                    mem_re      = 1'b1;
                    mem_raddr_a = lo_step;
                    mem_raddr_b = hi_step;
                    state_next  = ST_SWAP_A;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            err_reg   <= ERR_NONE;
            rd_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            err_reg   <= err_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_e <= DEPTH_E)
        else $error("fill level above capacity");

    a_fill_moves_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.valid && cmd.ready) |=> $stable(fill_reg))
        else $error("fill level changed without a command transfer");

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP_A || state_reg == ST_SWAP_B) |-> (lo_reg < hi_reg))
        else $error("swap pointers crossed");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.error != ERR_NONE) |-> (res.data == '0))
        else $error("failed operation returned data");

endmodule

>>> rtl/operand_stack_engine.sv
// ----------------------------------------------------------------------------
// operand_stack_engine
// Bounded operand stack: push, pop, reserve, drop, reverse top, peek from
// top or bottom, with depth and overflow/underflow reporting per command.
// ----------------------------------------------------------------------------
// Response path: a result waits in the response state, then the output
// register; reverse first swaps, each swap needing two memory writes.
// A new command is taken only after the last result leaves the sequencer.
// Reset: the fill level clears at once and the block is ready right away;
// the stack memory is not cleared, and entries are undefined until pushed.
module operand_stack_engine import ose_pkg::*; #(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ose_cmd_if.sink   cmd,
    ose_rsp_if.source rsp
);

    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

    // memory port signals
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr_a;
    logic [ADDR_W-1:0] mem_raddr_b;
    logic [WORD_W-1:0] mem_rdata_a;
    logic [WORD_W-1:0] mem_rdata_b;

    // sequencer result hand-off
    logic res_valid;
    logic res_ready;
    rsp_t res;

    // output register
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg;

    ose_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    ose_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // Take a new result when the register is empty or drains this cycle;
    // this frees the sequencer to accept the next command while a response
    // still waits on rsp.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload until the transfer completes
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg.data;
    assign rsp.depth = out_reg.depth;
    assign rsp.error = out_reg.error;

endmodule
